>>> rtl/rka_pkg.sv
// Shared types and constants for the random key argsort block.
package rka_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 6;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [POS_W-1:0]        pos_t;

	typedef struct packed {
		logic load;
		logic init;
		logic issue;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic rank_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/rka_stream_if.sv
// Valid/ready channel interfaces for key beats and permutation beats.
interface rka_key_if;
	import rka_pkg::*;

	logic valid;
	logic ready;
	key_t key;
	logic last;

	modport source (output valid, output key, output last, input ready);
	modport sink (input valid, input key, input last, output ready);
endinterface

interface rka_perm_if;
	import rka_pkg::*;

	logic valid;
	logic ready;
	pos_t position;
	logic final_res;
	logic dropped;

	modport source (output valid, output position, output final_res, output dropped,
		input ready);
	modport sink (input valid, input position, input final_res, input dropped,
		output ready);
endinterface

>>> rtl/rka_ctrl.sv
// Controller state machine: load, scan, drain one scan, emit one index.
module rka_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	input  logic                key_last,
	output logic                key_ready,
	input  rka_pkg::dp_status_t st,
	output rka_pkg::dp_cmd_t    cmd
);
	import rka_pkg::*;

	typedef enum logic [1:0] {
		S_LOAD,
		S_SCAN,
		S_TAIL,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		key_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				key_ready = 1'b1;
				cmd.load  = key_valid;
				cmd.init  = key_valid && key_last;
				if (key_valid && key_last) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (st.issue_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = st.rank_last ? S_LOAD : S_SCAN;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/rka_dp.sv
// Datapath: key memory, minimum-above-previous scan and result register.
module rka_dp #(
	parameter int MAX_KEYS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rka_pkg::key_t       key,
	input  rka_pkg::dp_cmd_t    cmd,
	output rka_pkg::dp_status_t st,
	output logic                out_valid,
	input  logic                out_ready,
	output rka_pkg::pos_t       position,
	output logic                final_res,
	output logic                dropped
);
	import rka_pkg::*;

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = $clog2(MAX_KEYS + 1);

	key_t             key_mem [MAX_KEYS];
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             room;

	logic [IDX_W-1:0] rd_addr_q;
	logic [IDX_W-1:0] rank_q;
	logic             rd_valid_s1;
	key_t             rd_key_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             best_valid_q;
	key_t             best_key_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             prev_valid_q;
	key_t             prev_key_q;
	logic [IDX_W-1:0] prev_idx_q;

	logic             above_prev;
	logic             below_best;
	logic             take;

	logic             out_valid_q;
	pos_t             position_q;
	logic             final_q;
	logic             dropped_q;

	assign room = count_q < CNT_W'(MAX_KEYS);

	assign above_prev = !prev_valid_q || (rd_key_s1 > prev_key_q) ||
		((rd_key_s1 == prev_key_q) && (rd_idx_s1 > prev_idx_q));
	assign below_best = !best_valid_q || (rd_key_s1 < best_key_q) ||
		((rd_key_s1 == best_key_q) && (rd_idx_s1 < best_idx_q));
	assign take = rd_valid_s1 && above_prev && below_best;

	assign st.issue_last = CNT_W'(rd_addr_q) == (count_q - CNT_W'(1));
	assign st.rank_last  = CNT_W'(rank_q) == (count_q - CNT_W'(1));
	assign st.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			key_mem[count_q[IDX_W-1:0]] <= key;
		end
		rd_key_s1 <= key_mem[rd_addr_q];
		rd_idx_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ovf_q        <= 1'b0;
			rd_addr_q    <= '0;
			rank_q       <= '0;
			rd_valid_s1  <= 1'b0;
			best_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				rd_addr_q    <= '0;
				rank_q       <= '0;
				best_valid_q <= 1'b0;
				prev_valid_q <= 1'b0;
			end else if (cmd.emit) begin
				rd_addr_q    <= '0;
				rank_q       <= rank_q + IDX_W'(1);
				best_valid_q <= 1'b0;
				prev_valid_q <= 1'b1;
				if (st.rank_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else begin
				if (cmd.issue) begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
				if (take) begin
					best_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !cmd.emit) begin
			best_key_q <= rd_key_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.emit) begin
			prev_key_q <= best_key_q;
			prev_idx_q <= best_idx_q;
			position_q <= POS_W'(best_idx_q);
			final_q    <= st.rank_last;
			dropped_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign final_res = final_q;
	assign dropped   = dropped_q;

endmodule

>>> rtl/random_key_argsort.sv
// Top level of the random key argsort block.
//
// Usage: key beats arrive on the keys channel, one signed Q16.16 key per beat,
// and the beat with last high closes the set. Keys are stored in arrival
// order; at most MAX_KEYS are kept and later keys of the set are discarded,
// which sets dropped on every permutation beat of that set.
// After the closing beat, the perm channel delivers one beat per stored key:
// the original index of the keys in ascending key order, equal keys in
// ascending index order, with final_res high on the last beat.
// Each index comes from one full pass over the stored keys (one read per
// cycle) that picks the smallest key above the one emitted before it;
// keys is not ready while the set is being ranked.
// The result sits in an output register: a stalled receiver holds it, and
// the next index, once its pass is done, waits for that register. Once the
// last result is in that register, keys is ready again for the next set.
// Reset (arst_n low) empties the set and drops any pending result; the
// key memory needs no clearing.
module random_key_argsort #(
	parameter int MAX_KEYS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	rka_key_if.sink     keys,
	rka_perm_if.source  perm
);
	import rka_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	rka_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (keys.valid),
		.key_last  (keys.last),
		.key_ready (keys.ready),
		.st        (st),
		.cmd       (cmd)
	);

	rka_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (keys.key),
		.cmd       (cmd),
		.st        (st),
		.out_valid (perm.valid),
		.out_ready (perm.ready),
		.position  (perm.position),
		.final_res (perm.final_res),
		.dropped   (perm.dropped)
	);

endmodule

>>> rtl/rka_checker.sv
// Port-level checker for the random key argsort block, with its bind.
module rka_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                keys_valid,
	input logic                keys_ready,
	input logic                keys_last,
	input logic                perm_valid,
	input logic                perm_ready,
	input rka_pkg::pos_t       perm_position,
	input logic                perm_final_res,
	input logic                perm_dropped
);
	import rka_pkg::*;

	a_perm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		perm_valid && !perm_ready |=> perm_valid)
		else $error("perm beat withdrawn while stalled");

	a_perm_stable: assert property (@(posedge clk) disable iff (!arst_n)
		perm_valid && !perm_ready |=> $stable(perm_position) &&
		$stable(perm_final_res) && $stable(perm_dropped))
		else $error("perm payload changed while stalled");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		keys_valid && keys_ready && keys_last |=> !keys_ready)
		else $error("keys ready right after closing beat");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(perm_valid) && !perm_final_res |-> !keys_ready)
		else $error("keys ready while a set is still being ranked");

endmodule

bind random_key_argsort rka_checker u_rka_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.keys_valid     (keys.valid),
	.keys_ready     (keys.ready),
	.keys_last      (keys.last),
	.perm_valid     (perm.valid),
	.perm_ready     (perm.ready),
	.perm_position  (perm.position),
	.perm_final_res (perm.final_res),
	.perm_dropped   (perm.dropped)
);

>>> tb/tb.sv
// Self-checking testbench for the random key argsort block.
`timescale 1ns / 1ps

module tb;
	import rka_pkg::*;

	localparam int MAX_KEYS = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_AFTER_BEATS = 25;
	localparam int RAND_ITEMS = 150;
	localparam int DRAIN_CYCLES = 200;
	localparam int TABLE_ROWS = 20;

	typedef struct packed {
		pos_t position;
		logic final_res;
		logic dropped;
	} perm_beat_t;

	typedef struct packed {
		key_t       key;
		logic       last;
		logic       typed;
		perm_beat_t beat;
	} key_row_t;

	localparam perm_beat_t ONLY_BEAT = '{position: '0, final_res: 1'b1, dropped: 1'b0};
	localparam perm_beat_t NO_BEAT = '{position: '0, final_res: 1'b0, dropped: 1'b0};

	localparam key_row_t KEY_TABLE [TABLE_ROWS] = '{
		'{32'sh8000_0000, 1'b1, 1'b1, ONLY_BEAT},
		'{32'sh7fff_ffff, 1'b1, 1'b1, ONLY_BEAT},
		'{32'sh7fff_ffff, 1'b0, 1'b0, NO_BEAT},
		'{32'sh8000_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'shffff_ffff, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0001, 1'b1, 1'b0, NO_BEAT},
		'{32'sh0000_0005, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0005, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0005, 1'b1, 1'b0, NO_BEAT},
		'{32'sh0001_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'shffff_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0001_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'sh8000_0000, 1'b0, 1'b0, NO_BEAT},
		'{32'sh8000_0000, 1'b1, 1'b0, NO_BEAT},
		'{32'sh0000_0003, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0002, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0001, 1'b0, 1'b0, NO_BEAT},
		'{32'sh0000_0000, 1'b1, 1'b0, NO_BEAT},
		'{32'sh0000_0000, 1'b1, 1'b1, ONLY_BEAT}
	};

	logic clk;
	logic arst_n;

	rka_key_if  keys_if ();
	rka_perm_if perm_if ();

	random_key_argsort #(
		.MAX_KEYS(MAX_KEYS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.keys   (keys_if),
		.perm   (perm_if)
	);

	key_t       stored_keys [MAX_KEYS];
	int         stored_cnt;
	logic       drop_flag;
	perm_beat_t sorted_beats [$];
	perm_beat_t perm_expected [$];

	int  error_count;
	int  beats_seen;
	int  cycle_count;
	bit  src_calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) begin
			return $urandom_range(1, 3);
		end else if (r < 19) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void argsort_accept(input key_t k, input logic is_last);
		int i;
		int j;
		int n;
		int rank;
		pos_t order [MAX_KEYS];
		perm_beat_t b;
		sorted_beats.delete();
		if (stored_cnt < MAX_KEYS) begin
			stored_keys[stored_cnt] = k;
			stored_cnt++;
		end else begin
			drop_flag = 1'b1;
		end
		if (!is_last) begin
			return;
		end
		n = stored_cnt;
		for (i = 0; i < n; i++) begin
			rank = 0;
			for (j = 0; j < n; j++) begin
				if (stored_keys[j] < stored_keys[i] ||
					(stored_keys[j] == stored_keys[i] && j < i)) begin
					rank++;
				end
			end
			order[rank] = pos_t'(i);
		end
		for (i = 0; i < n; i++) begin
			b.position = order[i];
			b.final_res = (i == n - 1);
			b.dropped = drop_flag;
			sorted_beats.insert(sorted_beats.size(), b);
		end
		stored_cnt = 0;
		drop_flag = 1'b0;
	endfunction

	task automatic send_key(input key_t k, input logic l, input logic typed,
		input perm_beat_t typed_beat);
		int g;
		@(negedge clk);
		keys_if.valid <= 1'b1;
		keys_if.key <= k;
		keys_if.last <= l;
		do @(posedge clk); while (!keys_if.ready);
		argsort_accept(k, l);
		if (typed && l) begin
			perm_expected.insert(perm_expected.size(), typed_beat);
		end else begin
			foreach (sorted_beats[i]) perm_expected.insert(perm_expected.size(), sorted_beats[i]);
		end
		if (src_calm || $urandom_range(0, 2) != 0) begin
			g = 0;
		end else begin
			g = pick_gap();
		end
		if (g > 0) begin
			@(negedge clk);
			keys_if.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	function automatic key_t random_key(input int mode);
		case (mode)
			0: begin
				return key_t'($urandom);
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh0000_8000;
					1: return 32'shffff_8000;
					2: return 32'sh0002_0000;
					default: return 32'sh0000_0000;
				endcase
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'shffff_ffff;
					default: return 32'sh0000_0000;
				endcase
			end
			default: begin
				return key_t'($signed($urandom_range(0, 15)) - 8);
			end
		endcase
	endfunction

	initial begin
		int sent;
		int set_idx;
		int set_len;
		int mode;
		arst_n = 1'b0;
		keys_if.valid = 1'b0;
		keys_if.key = '0;
		keys_if.last = 1'b0;
		stored_cnt = 0;
		drop_flag = 1'b0;
		error_count = 0;
		src_calm = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < TABLE_ROWS; r++) begin
			send_key(KEY_TABLE[r].key, KEY_TABLE[r].last, KEY_TABLE[r].typed,
				KEY_TABLE[r].beat);
		end

		sent = 0;
		set_idx = 0;
		while (sent < RAND_ITEMS) begin
			if (set_idx == 4) begin
				set_len = MAX_KEYS + 2;
			end else if ($urandom_range(0, 4) != 0) begin
				set_len = $urandom_range(1, 8);
			end else begin
				set_len = $urandom_range(9, 20);
			end
			mode = $urandom_range(0, 3);
			src_calm = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < set_len; k++) begin
				send_key(random_key(mode), k == set_len - 1, 1'b0, NO_BEAT);
			end
			sent += set_len;
			if (set_idx == 7) begin
				@(negedge clk);
				keys_if.valid <= 1'b0;
				while (perm_expected.size() != 0) @(posedge clk);
			end
			set_idx++;
		end
		@(negedge clk);
		keys_if.valid <= 1'b0;

		while (perm_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		int stall_left;
		int phase_cnt;
		bit hold_done;
		bit sink_calm;
		perm_if.ready = 1'b0;
		stall_left = 0;
		phase_cnt = 0;
		hold_done = 1'b0;
		sink_calm = 1'b0;
		forever begin
			@(negedge clk);
			phase_cnt++;
			if (phase_cnt % 300 == 0) begin
				sink_calm = ($urandom_range(0, 3) == 0);
			end
			if (stall_left == 0) begin
				if (!hold_done && beats_seen >= HOLD_AFTER_BEATS) begin
					hold_done = 1'b1;
					stall_left = HOLD_CYCLES;
				end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
			if (stall_left > 0) begin
				perm_if.ready <= 1'b0;
				stall_left--;
			end else begin
				perm_if.ready <= 1'b1;
			end
		end
	end

	initial beats_seen = 0;

	always @(posedge clk) begin
		perm_beat_t got;
		perm_beat_t want;
		if (arst_n && perm_if.valid && perm_if.ready) begin
			got = '{position: perm_if.position, final_res: perm_if.final_res,
				dropped: perm_if.dropped};
			beats_seen++;
			if (perm_expected.size() == 0) begin
				if (error_count < 10) begin
					$display("unexpected beat: pos=%0d fin=%b drop=%b",
						got.position, got.final_res, got.dropped);
				end
				error_count++;
			end else begin
				want = perm_expected.pop_front();
				if (got !== want) begin
					if (error_count < 10) begin
						$display("beat %0d: exp %0d/%b/%b got %0d/%b/%b",
							beats_seen, want.position, want.final_res, want.dropped,
							got.position, got.final_res, got.dropped);
					end
					error_count++;
				end
			end
		end
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

>>> filelist.f
rtl/rka_pkg.sv
rtl/rka_stream_if.sv
rtl/rka_ctrl.sv
rtl/rka_dp.sv
rtl/random_key_argsort.sv
rtl/rka_checker.sv
tb/tb.sv
